// ===== design/pva_pkg.sv =====
package pva_pkg;

  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int VOICE_W = 4;

  localparam logic OP_NOTE_OFF = 1'b0;
  localparam logic OP_NOTE_ON  = 1'b1;

  typedef struct packed {
    logic               event_start;
    logic [VOICE_W-1:0] voice;
    logic               found;
    logic               stolen;
    logic [NOTE_W-1:0]  note_out;
    logic [VEL_W-1:0]   velocity_out;
  } result_t;

endpackage

// ===== design/pva_if.sv =====
interface pva_evt_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [pva_pkg::NOTE_W-1:0]  note;
  logic [pva_pkg::VEL_W-1:0]   velocity;

  modport source (output valid, op, note, velocity, input ready);
  modport sink (input valid, op, note, velocity, output ready);
endinterface

interface pva_res_if;
  logic                        valid;
  logic                        ready;
  logic                        event_start;
  logic [pva_pkg::VOICE_W-1:0] voice;
  logic                        found;
  logic                        stolen;
  logic [pva_pkg::NOTE_W-1:0]  note_out;
  logic [pva_pkg::VEL_W-1:0]   velocity_out;

  modport source (output valid, event_start, voice, found, stolen, note_out, velocity_out,
                  input ready);
  modport sink (input valid, event_start, voice, found, stolen, note_out, velocity_out,
                output ready);
endinterface

// ===== design/polyphonic_voice_allocator_core.sv =====
// Note on: ST_ON registers the result once the output is free, then returns to idle.
// Note off: the note store is scanned one voice per cycle through its read port; a hit moves to
// ST_OFF and a miss on the last voice to ST_MISS, where the result is registered once the output
// is free; the next beat is taken once the block is back in idle.
// One event is in flight at a time; a new beat is taken while the previous result waits.
// Synchronous reset clears the busy flags, list pointers and the written flags of the link
// memories; no clearing pass is needed.
module polyphonic_voice_allocator_core #(
  parameter int VOICES = 16
) (
  input logic      clk,
  input logic      rst,
  pva_evt_if.sink  events,
  pva_res_if.source results
);

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam logic [IW-1:0] LAST = IW'(VOICES - 1);
  localparam logic [CW-1:0] FULL = CW'(VOICES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ON   = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_OFF  = 3'd3;
  localparam logic [2:0] ST_MISS = 3'd4;

  logic [2:0] state, state_next;

  logic [VOICES-1:0] busy;
  logic [CW-1:0]     busy_count;
  logic [IW-1:0]     old_asg, young_asg, old_rel, young_rel;

  logic [IW-1:0]               v_r;
  logic                        steal_r;
  logic [pva_pkg::NOTE_W-1:0]  note_r;
  logic [pva_pkg::VEL_W-1:0]   vel_r;

  logic                        res_valid;
  pva_pkg::result_t            res_q;

  // Memories.
  logic [pva_pkg::NOTE_W-1:0] note_mem [VOICES];
  logic [IW-1:0]              an_mem [VOICES];
  logic [IW-1:0]              ap_mem [VOICES];
  logic [IW-1:0]              rn_mem [VOICES];
  logic [VOICES-1:0]          an_set, ap_set, rn_set;

  logic [IW-1:0]              nm_rd_addr, chk_idx;
  logic [pva_pkg::NOTE_W-1:0] nm_q;
  logic                       nm_we;

  logic          an_rd_en, ap_rd_en, rn_rd_en;
  logic [IW-1:0] an_rd_addr, ap_rd_addr, rn_rd_addr;
  logic [IW-1:0] an_q, ap_q, rn_q, rn_q_addr;
  logic          an_q_ok, ap_q_ok, rn_q_ok;
  logic [IW-1:0] an_val, ap_val, rn_val;

  logic          an_we, ap_we, rn_we;
  logic [IW-1:0] an_wa, ap_wa, rn_wa, an_wd, ap_wd, rn_wd;

  logic accept, out_free, full, hit;

  assign accept   = events.valid && events.ready;
  assign out_free = !res_valid || results.ready;
  assign full     = (busy_count == FULL);
  assign hit      = busy[chk_idx] && (nm_q == note_r);

  // Entries never written read as their reset contents.
  assign an_val = an_q_ok ? an_q : '0;
  assign ap_val = ap_q_ok ? ap_q : '0;
  assign rn_val = rn_q_ok ? rn_q : ((rn_q_addr == LAST) ? '0 : rn_q_addr + IW'(1));

  assign events.ready         = (state == ST_IDLE);
  assign results.valid        = res_valid;
  assign results.event_start  = res_q.event_start;
  assign results.voice        = res_q.voice;
  assign results.found        = res_q.found;
  assign results.stolen       = res_q.stolen;
  assign results.note_out     = res_q.note_out;
  assign results.velocity_out = res_q.velocity_out;

  always_comb begin
    state_next = state;
    nm_rd_addr = (state == ST_SCAN) ? chk_idx + IW'(1) : '0;
    nm_we      = 1'b0;
    an_rd_en   = 1'b0;
    an_rd_addr = old_asg;
    ap_rd_en   = 1'b0;
    ap_rd_addr = chk_idx;
    rn_rd_en   = 1'b0;
    rn_rd_addr = old_rel;
    an_we      = 1'b0;
    an_wa      = young_asg;
    an_wd      = v_r;
    ap_we      = 1'b0;
    ap_wa      = v_r;
    ap_wd      = young_asg;
    rn_we      = 1'b0;
    rn_wa      = young_rel;
    rn_wd      = v_r;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (events.op == pva_pkg::OP_NOTE_ON) begin
            state_next = ST_ON;
            rn_rd_en   = !full;
            an_rd_en   = full;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_ON: begin
        if (out_free) begin
          state_next = ST_IDLE;
          nm_we      = 1'b1;
          ap_we      = 1'b1;
          an_we      = 1'b1;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_OFF;
          an_rd_en   = 1'b1;
          an_rd_addr = chk_idx;
          ap_rd_en   = 1'b1;
        end else if (chk_idx == LAST) begin
          state_next = ST_MISS;
        end
      end
      ST_OFF: begin
        if (out_free) begin
          state_next = ST_IDLE;
          rn_we      = 1'b1;
          // A voice in the middle of the age list is spliced out.
          if (old_asg != v_r && young_asg != v_r) begin
            an_we = 1'b1;
            an_wa = ap_val;
            an_wd = an_val;
            ap_we = 1'b1;
            ap_wa = an_val;
            ap_wd = ap_val;
          end
        end
      end
      ST_MISS: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Note store: read every cycle to feed the scan.
  always_ff @(posedge clk) begin
    if (nm_we) begin
      note_mem[v_r] <= note_r;
    end
    nm_q    <= note_mem[nm_rd_addr];
    chk_idx <= nm_rd_addr;
  end

  // Link memories.
  always_ff @(posedge clk) begin
    if (an_we) begin
      an_mem[an_wa] <= an_wd;
    end
    if (ap_we) begin
      ap_mem[ap_wa] <= ap_wd;
    end
    if (rn_we) begin
      rn_mem[rn_wa] <= rn_wd;
    end
    if (an_rd_en) begin
      an_q <= an_mem[an_rd_addr];
    end
    if (ap_rd_en) begin
      ap_q <= ap_mem[ap_rd_addr];
    end
    if (rn_rd_en) begin
      rn_q      <= rn_mem[rn_rd_addr];
      rn_q_addr <= rn_rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      an_set  <= '0;
      ap_set  <= '0;
      rn_set  <= '0;
      an_q_ok <= 1'b0;
      ap_q_ok <= 1'b0;
      rn_q_ok <= 1'b0;
    end else begin
      if (an_we) begin
        an_set[an_wa] <= 1'b1;
      end
      if (ap_we) begin
        ap_set[ap_wa] <= 1'b1;
      end
      if (rn_we) begin
        rn_set[rn_wa] <= 1'b1;
      end
      if (an_rd_en) begin
        an_q_ok <= an_set[an_rd_addr];
      end
      if (ap_rd_en) begin
        ap_q_ok <= ap_set[ap_rd_addr];
      end
      if (rn_rd_en) begin
        rn_q_ok <= rn_set[rn_rd_addr];
      end
    end
  end

  // Event registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      note_r  <= events.note;
      vel_r   <= events.velocity;
      steal_r <= full;
      v_r     <= full ? old_asg : old_rel;
    end else if (state == ST_SCAN && hit) begin
      v_r <= chk_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      busy       <= '0;
      busy_count <= '0;
      old_asg    <= '0;
      young_asg  <= '0;
      old_rel    <= '0;
      young_rel  <= LAST;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free && (state == ST_ON || state == ST_OFF || state == ST_MISS)) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          // An empty age list restarts at the head of the released queue.
          if (accept && events.op == pva_pkg::OP_NOTE_ON && busy_count == '0) begin
            old_asg   <= old_rel;
            young_asg <= old_rel;
          end
        end
        ST_ON: begin
          if (out_free) begin
            if (steal_r) begin
              old_asg <= an_val;
            end else begin
              old_rel    <= rn_val;
              busy_count <= busy_count + CW'(1);
            end
            young_asg  <= v_r;
            busy[v_r]  <= 1'b1;
          end
        end
        ST_OFF: begin
          if (out_free) begin
            young_rel <= v_r;
            if (full) begin
              old_rel <= v_r;
            end
            if (busy_count != '0) begin
              busy_count <= busy_count - CW'(1);
            end
            if (old_asg == v_r) begin
              old_asg <= an_val;
            end else if (young_asg == v_r) begin
              young_asg <= ap_val;
            end
            busy[v_r] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      unique case (state)
        ST_ON: begin
          res_q.event_start  <= 1'b1;
          res_q.voice        <= pva_pkg::VOICE_W'(v_r);
          res_q.found        <= 1'b1;
          res_q.stolen       <= steal_r;
          res_q.note_out     <= note_r;
          res_q.velocity_out <= vel_r;
        end
        ST_OFF: begin
          res_q.event_start  <= 1'b0;
          res_q.voice        <= pva_pkg::VOICE_W'(v_r);
          res_q.found        <= 1'b1;
          res_q.stolen       <= 1'b0;
          res_q.note_out     <= note_r;
          res_q.velocity_out <= '0;
        end
        ST_MISS: begin
          res_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy_count == CW'($countones(busy)))
    else $error("busy count disagrees with busy flags");

  a_steal_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ON && steal_r) |-> full)
    else $error("voice stolen while a voice was free");

  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OFF) |-> busy[v_r])
    else $error("released voice was not busy");

  a_on_marks_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ON && out_free) |=> busy[v_r])
    else $error("started voice not marked busy");

endmodule

// ===== verif/polyphonic_voice_allocator_core_test.sv =====
`timescale 1ns / 100ps

module polyphonic_voice_allocator_core_test;
  import pva_pkg::*;

  localparam int VOICES = 16;
  localparam int RANDOM_EVENTS = 1375;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Mirrors the allocator: per-voice notes, the age list of held voices and the
  // queue of released voices, plus the results still owed by the block.
  class voice_scoreboard #(int NV = 16);
    typedef bit [$clog2(NV)-1:0] vidx_t;

    bit [7:0]    held_note[NV];
    bit          busy[NV];
    vidx_t       age_next[NV];
    vidx_t       age_prev[NV];
    vidx_t       free_next[NV];
    int unsigned busy_voices;
    vidx_t       oldest_busy;
    vidx_t       youngest_busy;
    vidx_t       oldest_free;
    vidx_t       youngest_free;

    result_t     pending[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned starts;
    int unsigned steals;
    int unsigned releases;
    int unsigned misses;
    int unsigned full_releases;
    int unsigned emptied;

    function new();
      for (int i = 0; i < NV; i++) begin
        held_note[i] = 8'hFF;
        busy[i] = 1'b0;
        age_next[i] = '0;
        age_prev[i] = '0;
        free_next[i] = (i + 1 < NV) ? vidx_t'(i + 1) : '0;
      end
      busy_voices = 0;
      oldest_busy = '0;
      youngest_busy = '0;
      oldest_free = '0;
      youngest_free = vidx_t'(NV - 1);
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    // Picks the note of a random voice that is currently sounding.
    function bit pick_held(output logic [NOTE_W-1:0] n);
      int sounding[$];
      for (int i = 0; i < NV; i++)
        if (busy[i]) sounding.push_back(i);
      n = '0;
      if (sounding.size() == 0) return 1'b0;
      n = held_note[sounding[$urandom_range(0, sounding.size() - 1)]][NOTE_W-1:0];
      return 1'b1;
    endfunction

    function void note_event(logic op, logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
      result_t r = '0;
      vidx_t   v = '0;
      vidx_t   p;
      vidx_t   n;
      bit      hit = 1'b0;
      if (op == OP_NOTE_ON) begin
        if (busy_voices < NV) begin
          // With nothing held, the age list is rebuilt around the new voice.
          if (busy_voices == 0) begin
            oldest_busy = oldest_free;
            youngest_busy = oldest_free;
          end
          v = oldest_free;
          oldest_free = free_next[v];
          busy_voices++;
        end else begin
          v = oldest_busy;
          oldest_busy = age_next[v];
          r.stolen = 1'b1;
          steals++;
        end
        age_prev[v] = youngest_busy;
        age_next[youngest_busy] = v;
        youngest_busy = v;
        held_note[v] = {1'b0, note};
        busy[v] = 1'b1;
        r.event_start = 1'b1;
        r.voice = VOICE_W'(v);
        r.found = 1'b1;
        r.note_out = note;
        r.velocity_out = vel;
        starts++;
      end else begin
        for (int i = 0; i < NV; i++)
          if (!hit && busy[i] && held_note[i] == {1'b0, note}) begin
            v = vidx_t'(i);
            hit = 1'b1;
          end
        if (hit) begin
          free_next[youngest_free] = v;
          youngest_free = v;
          // The free queue was empty, so the released voice becomes its head.
          if (busy_voices == NV) begin
            oldest_free = v;
            full_releases++;
          end
          if (busy_voices > 0) busy_voices--;
          if (oldest_busy == v) begin
            oldest_busy = age_next[v];
          end else if (youngest_busy == v) begin
            youngest_busy = age_prev[v];
          end else begin
            p = age_prev[v];
            n = age_next[v];
            age_next[p] = n;
            age_prev[n] = p;
          end
          held_note[v] = 8'hFF;
          busy[v] = 1'b0;
          r.voice = VOICE_W'(v);
          r.found = 1'b1;
          r.note_out = note;
          releases++;
          if (busy_voices == 0) emptied++;
        end else begin
          misses++;
        end
      end
      pending.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d %s got %0d expected %0d", checked, name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result beat %p", got));
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("event_start", got.event_start, want.event_start);
      compare_field("voice", got.voice, want.voice);
      compare_field("found", got.found, want.found);
      compare_field("stolen", got.stolen, want.stolen);
      compare_field("note_out", got.note_out, want.note_out);
      compare_field("velocity_out", got.velocity_out, want.velocity_out);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic steady = 1'b0;
  int unsigned cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  voice_scoreboard #(VOICES) sb;

  pva_evt_if evt_bus ();
  pva_res_if res_bus ();

  polyphonic_voice_allocator_core #(.VOICES(VOICES)) dut (
    .clk(clk),
    .rst(rst),
    .events(evt_bus),
    .results(res_bus)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    evt_bus.valid = 1'b0;
    evt_bus.op = OP_NOTE_OFF;
    evt_bus.note = '0;
    evt_bus.velocity = '0;
    res_bus.ready = 1'b0;
  end

  // Result side: random stalls, one long hold-off while the sender keeps offering.
  always @(negedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sb.checked >= 400) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got.event_start = res_bus.event_start;
      got.voice = res_bus.voice;
      got.found = res_bus.found;
      got.stolen = res_bus.stolen;
      got.note_out = res_bus.note_out;
      got.velocity_out = res_bus.velocity_out;
      sb.check_result(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_event(logic op, logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
    while (!steady && $urandom_range(0, 99) < 31) begin
      evt_bus.valid <= 1'b0;
      @(negedge clk);
    end
    evt_bus.valid <= 1'b1;
    evt_bus.op <= op;
    evt_bus.note <= note;
    evt_bus.velocity <= vel;
    do @(posedge clk); while (!evt_bus.ready);
    sb.note_event(op, note, vel);
    @(negedge clk);
  endtask

  task automatic send_random(int k);
    logic [NOTE_W-1:0] n;
    int on_pct;
    on_pct = ((k / 60) % 2 == 0) ? 70 : 35;
    if ($urandom_range(0, 99) < 8) begin
      send_event(logic'($urandom_range(0, 1)), NOTE_W'($urandom_range(0, 127)),
                 VEL_W'($urandom_range(0, 127)));
    end else if ($urandom_range(0, 99) < on_pct) begin
      // Half the notes come from one octave so that duplicates are common.
      n = ($urandom_range(0, 1) == 1) ? NOTE_W'($urandom_range(48, 59))
                                      : NOTE_W'($urandom_range(0, 127));
      send_event(OP_NOTE_ON, n, VEL_W'($urandom_range(0, 127)));
    end else begin
      if (!sb.pick_held(n)) n = NOTE_W'($urandom_range(0, 127));
      send_event(OP_NOTE_OFF, n, VEL_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still expected", cycle_count,
             sb.outstanding());
    $display("status: fail");
    $finish;
  end

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: a miss from reset, extremes, duplicates, emptying, stealing and a
    // release while every voice is busy.
    send_event(OP_NOTE_OFF, 7'd5, 7'd33);
    send_event(OP_NOTE_ON, 7'd0, 7'd0);
    send_event(OP_NOTE_ON, 7'd127, 7'd127);
    send_event(OP_NOTE_ON, 7'd0, 7'd64);
    send_event(OP_NOTE_OFF, 7'd0, 7'd127);
    send_event(OP_NOTE_OFF, 7'd0, 7'd0);
    send_event(OP_NOTE_OFF, 7'd127, 7'd1);
    send_event(OP_NOTE_ON, 7'd60, 7'd100);
    for (int i = 1; i < VOICES; i++)
      send_event(OP_NOTE_ON, NOTE_W'(i), VEL_W'(i * 8));
    send_event(OP_NOTE_ON, 7'd100, 7'd127);
    send_event(OP_NOTE_OFF, 7'd100, 7'd42);

    for (int k = 0; k < RANDOM_EVENTS; k++) begin
      steady <= (k >= 900 && k < 1150);
      if (k == 600) begin
        evt_bus.valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge clk);
      end
      send_random(k);
    end
    evt_bus.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (VOICES + 8) @(posedge clk);

    $display("covered %0d results: %0d note on (%0d stolen), %0d releases, %0d misses",
             sb.checked, sb.starts, sb.steals, sb.releases, sb.misses);
    $display("releases with every voice busy: %0d, times all voices went quiet: %0d",
             sb.full_releases, sb.emptied);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== polyphonic_voice_allocator_core.f =====
design/pva_pkg.sv
design/pva_if.sv
design/polyphonic_voice_allocator_core.sv
verif/polyphonic_voice_allocator_core_test.sv
